// ----- design/dlbb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlbb_pkg: shared types and constants for the depth ladder book builder
// Op codes, aggressor codes, register indices, field widths and the front-to-back command.
// ----------------------------------------------------------------------------
package dlbb_pkg;

   localparam int PRICE_W = 48;
   localparam int SIZE_W  = 24;
   localparam int TOL_W   = 40;
   localparam int SEQ_W   = 32;

   localparam logic [2:0] OP_ADD    = 3'd0;
   localparam logic [2:0] OP_MODIFY = 3'd1;
   localparam logic [2:0] OP_REMOVE = 3'd2;
   localparam logic [2:0] OP_TRADE  = 3'd3;
   localparam logic [2:0] OP_RESET  = 3'd4;

   localparam logic [1:0] AGG_BUYER  = 2'd0;
   localparam logic [1:0] AGG_SELLER = 2'd1;
   localparam logic [1:0] AGG_NONE   = 2'd2;

   localparam logic [0:0] CSR_ROW_LIMIT = 1'b0;
   localparam logic [0:0] CSR_PRICE_TOL = 1'b1;

   // command passed from the front end to the back end
   typedef struct packed {
      logic [2:0]                op;
      logic                      side;
      logic [7:0]                position;
      logic signed [PRICE_W-1:0] price;
      logic [SIZE_W-1:0]         size;
   } cmd_type;

endpackage

`default_nettype wire

// ----- design/dlbb_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlbb_front: command intake
// Accepts commands and queues them for the back end.
// ----------------------------------------------------------------------------
module dlbb_front (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_start,
   output logic                   req_busy,
   input  wire dlbb_pkg::cmd_type req_cmd,
   output logic                   q_valid,
   output dlbb_pkg::cmd_type      q_cmd,
   input  wire                    q_pop
);
   import dlbb_pkg::*;

   localparam int DEPTH = 2;

   cmd_type    mem_ff [DEPTH];
   logic [0:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   assign req_busy = (cnt_ff == 2'(DEPTH));
   assign push     = req_start && !req_busy;
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_cmd    = mem_ff[rp_ff];

   // advance pointers and occupancy
   always_comb begin
      wp_in  = push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = q_pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // store an accepted transfer
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= req_cmd;
      end
   end

endmodule

`default_nettype wire

// ----- design/dlbb_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlbb_back: ladder engine
// Applies one command per pass: shift, truncate, compact one row per cycle,
// then streams the snapshot levels.
// ----------------------------------------------------------------------------
module dlbb_back #(
   parameter int MAX_ROWS   = 16,
   parameter int OUT_LEVELS = 10
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        q_valid,
   input  wire dlbb_pkg::cmd_type     q_cmd,
   output logic                       q_pop,
   input  wire [4:0]                  row_limit,
   input  wire [dlbb_pkg::TOL_W-1:0]  price_tolerance,
   output logic                       rsp_valid,
   output logic [3:0]                 rsp_level,
   output logic signed [47:0]         rsp_bid_price,
   output logic [23:0]                rsp_bid_size,
   output logic signed [47:0]         rsp_ask_price,
   output logic [23:0]                rsp_ask_size,
   output logic                       rsp_is_trade,
   output logic signed [47:0]         rsp_trade_price,
   output logic [23:0]                rsp_trade_size,
   output logic [1:0]                 rsp_aggressor,
   output logic [31:0]                rsp_sequence_number,
   output logic                       rsp_last
);
   import dlbb_pkg::*;

   localparam int RI_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CN_W = $clog2(MAX_ROWS + 1);
   localparam int LV_W = (OUT_LEVELS > 1) ? $clog2(OUT_LEVELS) : 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_PACK = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic signed [PRICE_W-1:0] bp_ff [MAX_ROWS];
   logic [SIZE_W-1:0]         bs_ff [MAX_ROWS];
   logic signed [PRICE_W-1:0] ap_ff [MAX_ROWS];
   logic [SIZE_W-1:0]         as_ff [MAX_ROWS];
   logic [CN_W-1:0]           bc_ff, ac_ff;
   logic signed [PRICE_W-1:0] pbid_ff, pask_ff;
   logic                      pbv_ff, pav_ff;
   logic [SEQ_W-1:0]          seq_ff;
   logic [1:0]                st_ff;
   logic                      side_ff;
   logic [CN_W-1:0]           n_ff, i_ff, k_ff;
   logic [LV_W-1:0]           lv_ff;
   logic                      trd_ff;
   logic signed [PRICE_W-1:0] tp_ff;
   logic [SIZE_W-1:0]         ts_ff;
   logic [1:0]                agg_ff;

   // working side selection
   logic signed [PRICE_W-1:0] wp [MAX_ROWS];
   logic [SIZE_W-1:0]         ws [MAX_ROWS];
   logic [CN_W-1:0]           wn;
   logic [CN_W-1:0]           lim;
   logic                      ok;
   logic [CN_W-1:0]           n_new;
   logic signed [PRICE_W-1:0] np [MAX_ROWS];
   logic [SIZE_W-1:0]         ns [MAX_ROWS];

   // quote rule
   logic signed [PRICE_W+1:0] tp, eps, a0, b0, pa, pb;
   logic [1:0]                agg;

   always_comb begin
      wn  = q_cmd.side ? bc_ff : ac_ff;
      ok  = 1'b0;
      n_new = wn;
      for (int j = 0; j < MAX_ROWS; j++) begin
         wp[j] = q_cmd.side ? bp_ff[j] : ap_ff[j];
         ws[j] = q_cmd.side ? bs_ff[j] : as_ff[j];
         np[j] = wp[j];
         ns[j] = ws[j];
      end
      // position beyond 8-bit count range check
      if (q_cmd.position > 8'(wn) && q_cmd.op != OP_REMOVE) begin
         ok = 1'b0;
      end else begin
         unique case (q_cmd.op)
            OP_ADD: begin
               ok = 1'b1;
               if (q_cmd.position < 8'(MAX_ROWS)) begin
                  for (int j = 0; j < MAX_ROWS; j++) begin
                     if (j == int'(q_cmd.position)) begin
                        np[j] = q_cmd.price;
                        ns[j] = q_cmd.size;
                     end
                  end
                  for (int j = 1; j < MAX_ROWS; j++) begin
                     if (j > int'(q_cmd.position)) begin
                        np[j] = wp[j-1];
                        ns[j] = ws[j-1];
                     end
                  end
                  n_new = (wn >= CN_W'(MAX_ROWS)) ? CN_W'(MAX_ROWS) : wn + 1'b1;
               end else begin
                  n_new = (wn >= CN_W'(MAX_ROWS)) ? CN_W'(MAX_ROWS - 1) : wn;
               end
            end
            OP_MODIFY: begin
               ok = 1'b1;
               for (int j = 0; j < MAX_ROWS; j++) begin
                  if (j == int'(q_cmd.position)) begin
                     np[j] = q_cmd.price;
                     ns[j] = q_cmd.size;
                  end
               end
               if (8'(wn) == q_cmd.position && wn < CN_W'(MAX_ROWS)) n_new = wn + 1'b1;
            end
            OP_REMOVE: begin
               ok = (q_cmd.position < 8'(wn));
               for (int j = 0; j < MAX_ROWS - 1; j++) begin
                  if (j >= int'(q_cmd.position)) begin
                     np[j] = wp[j+1];
                     ns[j] = ws[j+1];
                  end
               end
               n_new = wn - 1'b1;
            end
            default: ok = 1'b0;
         endcase
      end
      // clamp row limit
      if (row_limit == 5'd0) lim = CN_W'(1);
      else if (int'(row_limit) > MAX_ROWS) lim = CN_W'(MAX_ROWS);
      else lim = CN_W'(row_limit);
      if (n_new > lim) n_new = lim;
   end

   // aggressor classification
   always_comb begin
      tp  = (PRICE_W+2)'(q_cmd.price);
      eps = (PRICE_W+2)'({1'b0, price_tolerance});
      a0  = (PRICE_W+2)'(ap_ff[0]) - eps;
      b0  = (PRICE_W+2)'(bp_ff[0]) + eps;
      pa  = (PRICE_W+2)'(pask_ff) - eps;
      pb  = (PRICE_W+2)'(pbid_ff) + eps;
      priority if (tp >= a0)           agg = AGG_BUYER;
      else if (tp <= b0)               agg = AGG_SELLER;
      else if (pav_ff && tp >= pa)     agg = AGG_BUYER;
      else if (pbv_ff && tp <= pb)     agg = AGG_SELLER;
      else                             agg = AGG_NONE;
   end

   logic both;
   assign both  = (bc_ff != '0) && (ac_ff != '0);
   assign q_pop = (st_ff == ST_IDLE) && q_valid;

   logic [RI_W-1:0] ii, kk;
   assign ii = i_ff[RI_W-1:0];
   assign kk = k_ff[RI_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= ST_IDLE;
         bc_ff  <= '0;
         ac_ff  <= '0;
         pbv_ff <= 1'b0;
         pav_ff <= 1'b0;
         pbid_ff <= '0;
         pask_ff <= '0;
         seq_ff <= '0;
         lv_ff  <= '0;
         for (int j = 0; j < MAX_ROWS; j++) begin
            bp_ff[j] <= '0; bs_ff[j] <= '0; ap_ff[j] <= '0; as_ff[j] <= '0;
         end
      end else begin
         unique case (st_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  if (q_cmd.op == OP_TRADE) begin
                     if (q_cmd.size != '0 && both) begin
                        trd_ff <= 1'b1; tp_ff <= q_cmd.price; ts_ff <= q_cmd.size;
                        agg_ff <= agg; seq_ff <= seq_ff + 1'b1; lv_ff <= '0;
                        st_ff <= ST_EMIT;
                     end
                  end else if (q_cmd.op == OP_RESET) begin
                     for (int j = 0; j < MAX_ROWS; j++) begin
                        bp_ff[j] <= '0; bs_ff[j] <= '0; ap_ff[j] <= '0; as_ff[j] <= '0;
                     end
                     bc_ff <= '0; ac_ff <= '0;
                     pbid_ff <= '0; pask_ff <= '0; pbv_ff <= 1'b0; pav_ff <= 1'b0;
                     trd_ff <= 1'b0; tp_ff <= '0; ts_ff <= '0; agg_ff <= AGG_NONE;
                     seq_ff <= seq_ff + 1'b1; lv_ff <= '0;
                     st_ff <= ST_EMIT;
                  end else begin
                     // latch previous touch
                     if (bc_ff != '0) begin pbid_ff <= bp_ff[0]; pbv_ff <= 1'b1; end
                     if (ac_ff != '0) begin pask_ff <= ap_ff[0]; pav_ff <= 1'b1; end
                     if (ok) begin
                        for (int j = 0; j < MAX_ROWS; j++) begin
                           if (q_cmd.side) begin bp_ff[j] <= np[j]; bs_ff[j] <= ns[j]; end
                           else begin ap_ff[j] <= np[j]; as_ff[j] <= ns[j]; end
                        end
                        side_ff <= q_cmd.side;
                        n_ff <= n_new; i_ff <= '0; k_ff <= '0;
                        st_ff <= ST_PACK;
                     end
                  end
               end
            end
            ST_PACK: begin
               // compact one row per cycle
               if (i_ff == n_ff) begin
                  if (side_ff) bc_ff <= k_ff; else ac_ff <= k_ff;
                  if (k_ff != '0 && (side_ff ? ac_ff != '0 : bc_ff != '0)) begin
                     trd_ff <= 1'b0; tp_ff <= '0; ts_ff <= '0; agg_ff <= AGG_NONE;
                     seq_ff <= seq_ff + 1'b1; lv_ff <= '0;
                     st_ff <= ST_EMIT;
                  end else begin
                     st_ff <= ST_IDLE;
                  end
               end else begin
                  if (side_ff) begin
                     if (bs_ff[ii] != '0) begin
                        bp_ff[kk] <= bp_ff[ii]; bs_ff[kk] <= bs_ff[ii]; k_ff <= k_ff + 1'b1;
                     end
                  end else begin
                     if (as_ff[ii] != '0) begin
                        ap_ff[kk] <= ap_ff[ii]; as_ff[kk] <= as_ff[ii]; k_ff <= k_ff + 1'b1;
                     end
                  end
                  i_ff <= i_ff + 1'b1;
               end
            end
            ST_EMIT: begin
               if (int'(lv_ff) == OUT_LEVELS - 1) st_ff <= ST_IDLE;
               lv_ff <= lv_ff + 1'b1;
            end
            default: st_ff <= ST_IDLE;
         endcase
      end
   end

   // present the current level
   logic hb, ha;
   logic [RI_W-1:0] li;
   always_comb begin
      li = RI_W'(lv_ff);
      hb = (CN_W+LV_W)'(lv_ff) < (CN_W+LV_W)'(bc_ff) && int'(lv_ff) < MAX_ROWS;
      ha = (CN_W+LV_W)'(lv_ff) < (CN_W+LV_W)'(ac_ff) && int'(lv_ff) < MAX_ROWS;
      rsp_valid           = (st_ff == ST_EMIT);
      rsp_level           = 4'(lv_ff);
      rsp_bid_price       = hb ? bp_ff[li] : '0;
      rsp_bid_size        = hb ? bs_ff[li] : '0;
      rsp_ask_price       = ha ? ap_ff[li] : '0;
      rsp_ask_size        = ha ? as_ff[li] : '0;
      rsp_is_trade        = trd_ff;
      rsp_trade_price     = tp_ff;
      rsp_trade_size      = ts_ff;
      rsp_aggressor       = agg_ff;
      rsp_sequence_number = seq_ff;
      rsp_last            = (int'(lv_ff) == OUT_LEVELS - 1);
   end

endmodule

`default_nettype wire

// ----- design/depth_ladder_book_builder.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// depth_ladder_book_builder: market-by-price bid/ask ladder
// Front intake queue feeding a ladder engine that emits level snapshots.
// ----------------------------------------------------------------------------
// Commands enter through a two-entry queue; busy rises only when it is full.
// The engine takes one command at a time. The cycle that pops a command also
// applies its shift; a depth change then scans one row per cycle up to the
// clamped row count and then closes the pass, and a snapshot streams its
// OUT_LEVELS levels, one level per cycle on rsp_valid.
// The receiver cannot stall; every level appears for exactly one cycle.
// ----------------------------------------------------------------------------
module depth_ladder_book_builder #(
   parameter int MAX_ROWS   = 16,
   parameter int OUT_LEVELS = 10
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   output logic                busy,
   input  wire [2:0]           req_op,
   input  wire                 req_side,
   input  wire [7:0]           req_position,
   input  wire signed [47:0]   req_price,
   input  wire [23:0]          req_size,
   input  wire                 csr_write,
   input  wire [0:0]           csr_index,
   input  wire [39:0]          csr_data,
   output logic                rsp_valid,
   output logic [3:0]          rsp_level,
   output logic signed [47:0]  rsp_bid_price,
   output logic [23:0]         rsp_bid_size,
   output logic signed [47:0]  rsp_ask_price,
   output logic [23:0]         rsp_ask_size,
   output logic                rsp_is_trade,
   output logic signed [47:0]  rsp_trade_price,
   output logic [23:0]         rsp_trade_size,
   output logic [1:0]          rsp_aggressor,
   output logic [31:0]         rsp_sequence_number,
   output logic                rsp_last
);
   import dlbb_pkg::*;

   logic [4:0]       row_limit_ff;
   logic [TOL_W-1:0] tol_ff;
   cmd_type          cmd, q_cmd;
   logic             q_valid, q_pop;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         row_limit_ff <= 5'd10;
         tol_ff       <= TOL_W'(62500000);
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_ROW_LIMIT: row_limit_ff <= csr_data[4:0];
            CSR_PRICE_TOL: tol_ff       <= csr_data;
            default: ;
         endcase
      end
   end

   assign cmd = '{op: req_op, side: req_side, position: req_position,
                  price: req_price, size: req_size};

   dlbb_front u_front (
      .clock(clock), .reset(reset), .req_start(start), .req_busy(busy),
      .req_cmd(cmd), .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
   );

   dlbb_back #(.MAX_ROWS(MAX_ROWS), .OUT_LEVELS(OUT_LEVELS)) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_cmd(q_cmd),
      .q_pop(q_pop), .row_limit(row_limit_ff), .price_tolerance(tol_ff),
      .rsp_valid(rsp_valid), .rsp_level(rsp_level),
      .rsp_bid_price(rsp_bid_price), .rsp_bid_size(rsp_bid_size),
      .rsp_ask_price(rsp_ask_price), .rsp_ask_size(rsp_ask_size),
      .rsp_is_trade(rsp_is_trade), .rsp_trade_price(rsp_trade_price),
      .rsp_trade_size(rsp_trade_size), .rsp_aggressor(rsp_aggressor),
      .rsp_sequence_number(rsp_sequence_number), .rsp_last(rsp_last)
   );

endmodule

`default_nettype wire

// ----- dv/dlbb_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlbb_checker: book prediction and snapshot scoreboard
// Watches the command, register and snapshot channels, keeps its own copy of
// both ladders, predicts every snapshot level and compares it field by field.
// ----------------------------------------------------------------------------
module dlbb_checker
   import dlbb_pkg::*;
(
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   input  wire                busy,
   input  wire [2:0]          req_op,
   input  wire                req_side,
   input  wire [7:0]          req_position,
   input  wire signed [47:0]  req_price,
   input  wire [23:0]         req_size,
   input  wire                csr_write,
   input  wire [0:0]          csr_index,
   input  wire [39:0]         csr_data,
   input  wire                rsp_valid,
   input  wire [3:0]          rsp_level,
   input  wire signed [47:0]  rsp_bid_price,
   input  wire [23:0]         rsp_bid_size,
   input  wire signed [47:0]  rsp_ask_price,
   input  wire [23:0]         rsp_ask_size,
   input  wire                rsp_is_trade,
   input  wire signed [47:0]  rsp_trade_price,
   input  wire [23:0]         rsp_trade_size,
   input  wire [1:0]          rsp_aggressor,
   input  wire [31:0]         rsp_sequence_number,
   input  wire                rsp_last,
   output int                 fail_count,
   output int                 levels_pending,
   output int                 bid_rows,
   output int                 ask_rows
);

   localparam int ROWS   = 16;
   localparam int LEVELS = 10;
   localparam bit ASK    = 1'b0;
   localparam bit BID    = 1'b1;

   typedef struct {
      logic [3:0]         level;
      logic signed [47:0] bid_price;
      logic [23:0]        bid_size;
      logic signed [47:0] ask_price;
      logic [23:0]        ask_size;
      logic               is_trade;
      logic signed [47:0] trade_price;
      logic [23:0]        trade_size;
      logic [1:0]         aggressor;
      logic [31:0]        sequence_number;
      logic               last;
   } level_type;

   level_type          level_queue[$];
   logic [4:0]         row_limit;
   logic [39:0]        tolerance;
   logic signed [47:0] row_price[2][ROWS];
   logic [23:0]        row_size[2][ROWS];
   int                 row_count[2];
   logic signed [47:0] prev_bid, prev_ask;
   bit                 prev_bid_ok, prev_ask_ok;
   logic [31:0]        snap_number;

   function automatic void clear_book();
      for (int sd = 0; sd < 2; sd++) begin
         row_count[sd] = 0;
         for (int i = 0; i < ROWS; i++) begin
            row_price[sd][i] = '0;
            row_size[sd][i]  = '0;
         end
      end
      prev_bid = '0; prev_ask = '0;
      prev_bid_ok = 1'b0; prev_ask_ok = 1'b0;
   endfunction

   // queue one level per output row of the current book
   function automatic void queue_snapshot(bit trade, logic signed [47:0] tp,
                                          logic [23:0] ts, logic [1:0] agg);
      level_type e;
      snap_number = snap_number + 32'd1;
      for (int i = 0; i < LEVELS; i++) begin
         e.level           = i[3:0];
         e.bid_price       = (i < row_count[BID]) ? row_price[BID][i] : '0;
         e.bid_size        = (i < row_count[BID]) ? row_size[BID][i]  : '0;
         e.ask_price       = (i < row_count[ASK]) ? row_price[ASK][i] : '0;
         e.ask_size        = (i < row_count[ASK]) ? row_size[ASK][i]  : '0;
         e.is_trade        = trade;
         e.trade_price     = trade ? tp : '0;
         e.trade_size      = trade ? ts : '0;
         e.aggressor       = trade ? agg : AGG_NONE;
         e.sequence_number = snap_number;
         e.last            = (i == LEVELS - 1);
         level_queue.insert(level_queue.size(), e);
      end
   endfunction

   // quote rule: current touch first, then previous touch
   function automatic logic [1:0] aggressor_of(logic signed [47:0] p);
      longint eps, px;
      eps = longint'({24'b0, tolerance});
      px  = longint'(p);
      if (px >= longint'(row_price[ASK][0]) - eps) return AGG_BUYER;
      if (px <= longint'(row_price[BID][0]) + eps) return AGG_SELLER;
      if (prev_ask_ok && px >= longint'(prev_ask) - eps) return AGG_BUYER;
      if (prev_bid_ok && px <= longint'(prev_bid) + eps) return AGG_SELLER;
      return AGG_NONE;
   endfunction

   // change one side; returns 0 when the position is out of step or the op is not a depth change
   function automatic bit change_ladder(logic [2:0] op, bit sd, int at,
                                        logic signed [47:0] p, logic [23:0] s);
      int n, lim, k;
      n = row_count[sd];
      if (op == OP_ADD) begin
         if (at > n) return 1'b0;
         if (n >= ROWS) n = ROWS - 1;
         if (at < ROWS) begin
            for (int i = n; i > at; i--) begin
               row_price[sd][i] = row_price[sd][i-1];
               row_size[sd][i]  = row_size[sd][i-1];
            end
            row_price[sd][at] = p;
            row_size[sd][at]  = s;
            n++;
         end
      end else if (op == OP_MODIFY) begin
         if (at > n) return 1'b0;
         if (at < n) begin
            row_price[sd][at] = p;
            row_size[sd][at]  = s;
         end else if (n < ROWS) begin
            row_price[sd][n] = p;
            row_size[sd][n]  = s;
            n++;
         end
      end else if (op == OP_REMOVE) begin
         if (at >= n) return 1'b0;
         for (int i = at; i + 1 < n; i++) begin
            row_price[sd][i] = row_price[sd][i+1];
            row_size[sd][i]  = row_size[sd][i+1];
         end
         n--;
      end else begin
         return 1'b0;
      end
      lim = (row_limit == 0) ? 1 : (row_limit > ROWS) ? ROWS : int'(row_limit);
      if (n > lim) n = lim;
      // squeeze out empty rows
      k = 0;
      for (int i = 0; i < n; i++) begin
         if (row_size[sd][i] != 0) begin
            row_price[sd][k] = row_price[sd][i];
            row_size[sd][k]  = row_size[sd][i];
            k++;
         end
      end
      row_count[sd] = k;
      return 1'b1;
   endfunction

   function automatic void predict(logic [2:0] op, bit sd, int at,
                                   logic signed [47:0] p, logic [23:0] s);
      if (op == OP_TRADE) begin
         if (s != 0 && row_count[BID] != 0 && row_count[ASK] != 0)
            queue_snapshot(1'b1, p, s, aggressor_of(p));
         return;
      end
      if (op == OP_RESET) begin
         clear_book();
         queue_snapshot(1'b0, '0, '0, AGG_NONE);
         return;
      end
      // latch previous touch
      if (row_count[BID] != 0) begin
         prev_bid = row_price[BID][0]; prev_bid_ok = 1'b1;
      end
      if (row_count[ASK] != 0) begin
         prev_ask = row_price[ASK][0]; prev_ask_ok = 1'b1;
      end
      if (!change_ladder(op, sd, at, p, s)) return;
      if (row_count[BID] != 0 && row_count[ASK] != 0)
         queue_snapshot(1'b0, '0, '0, AGG_NONE);
   endfunction

   function automatic void check_field(string name, longint want, longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      level_type e;
      if (reset) begin
         row_limit   <= 5'd10;
         tolerance   <= 40'd62500000;
         snap_number = '0;
         clear_book();
         level_queue.delete();
         fail_count  <= 0;
      end else begin
         // compare the level on the result port
         if (rsp_valid) begin
            if (level_queue.size() == 0) begin
               $error("snapshot level %0d with nothing expected", rsp_level);
               fail_count++;
            end else begin
               e = level_queue.pop_front();
               check_field("level", e.level, rsp_level);
               check_field("bid_price", e.bid_price, rsp_bid_price);
               check_field("bid_size", e.bid_size, rsp_bid_size);
               check_field("ask_price", e.ask_price, rsp_ask_price);
               check_field("ask_size", e.ask_size, rsp_ask_size);
               check_field("is_trade", e.is_trade, rsp_is_trade);
               check_field("trade_price", e.trade_price, rsp_trade_price);
               check_field("trade_size", e.trade_size, rsp_trade_size);
               check_field("aggressor", e.aggressor, rsp_aggressor);
               check_field("sequence_number", e.sequence_number,
                           rsp_sequence_number);
               check_field("last", e.last, rsp_last);
            end
         end
         // track register writes
         if (csr_write) begin
            if (csr_index == CSR_ROW_LIMIT) row_limit <= csr_data[4:0];
            else                            tolerance <= csr_data;
         end
         // predict each accepted command
         if (start && !busy)
            predict(req_op, req_side, int'(req_position), req_price, req_size);
      end
      levels_pending <= level_queue.size();
      bid_rows       <= row_count[BID];
      ask_rows       <= row_count[ASK];
   end

endmodule

// ----- dv/tb_depth_ladder_book_builder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_depth_ladder_book_builder: stimulus and verdict for the book builder
// Drives directed and random depth, trade and reset commands through several
// register settings; the checker predicts and compares every snapshot level.
// ----------------------------------------------------------------------------
module tb_depth_ladder_book_builder;
   import dlbb_pkg::*;

   localparam longint BASE = 64'd1000000000;

   logic               clock, reset, start, busy;
   logic [2:0]         req_op;
   logic               req_side;
   logic [7:0]         req_position;
   logic signed [47:0] req_price;
   logic [23:0]        req_size;
   logic               csr_write;
   logic [0:0]         csr_index;
   logic [39:0]        csr_data;
   logic               rsp_valid, rsp_is_trade, rsp_last;
   logic [3:0]         rsp_level;
   logic signed [47:0] rsp_bid_price, rsp_ask_price, rsp_trade_price;
   logic [23:0]        rsp_bid_size, rsp_ask_size, rsp_trade_size;
   logic [1:0]         rsp_aggressor;
   logic [31:0]        rsp_sequence_number;
   int                 fail_count, levels_pending, bid_rows, ask_rows;
   bit                 steady;

   depth_ladder_book_builder i_dut (.*);
   dlbb_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3ms;
      $display("[depth_ladder_book_builder] ERROR");
      $finish;
   end

   // hold the command until a transfer happens, with random gaps before it
   task automatic send(logic [2:0] op, logic sd, logic [7:0] pos,
                       logic signed [47:0] p, logic [23:0] s);
      bit taken;
      if (!steady && $urandom_range(99) < 27) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start <= 1'b1; req_op <= op; req_side <= sd; req_position <= pos;
      req_price <= p; req_size <= s;
      do begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end while (!taken);
   endtask

   // pause until the book is idle and no snapshot levels are still expected
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (levels_pending != 0 || busy) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_reg(logic [0:0] idx, logic [39:0] val);
      csr_write <= 1'b1; csr_index <= idx; csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // mostly depth changes near a common price, plus trades, resets and some noise
   task automatic random_command();
      int r, n;
      logic [2:0] op;
      logic sd;
      logic [7:0] pos;
      logic signed [47:0] p;
      logic [23:0] s;
      r  = $urandom_range(99);
      sd = 1'($urandom_range(1));
      n  = sd ? bid_rows : ask_rows;
      op = (r < 40) ? OP_ADD : (r < 65) ? OP_MODIFY : (r < 80) ? OP_REMOVE :
           (r < 93) ? OP_TRADE : (r < 96) ? OP_RESET : 3'($urandom_range(5, 7));
      pos = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(n + 1));
      p = ($urandom_range(9) == 0) ? 48'({$urandom, $urandom}) :
          48'(BASE + $urandom_range(400) * 25000000 - 5000000000);
      r = $urandom_range(19);
      s = (r == 0) ? 24'd0 : (r == 1) ? 24'hFFFFFF : (r == 2) ? 24'($urandom) :
          24'($urandom_range(1, 500));
      send(op, sd, pos, p, s);
   endtask

   initial begin
      int failed;
      reset = 1'b1; start = 1'b0; steady = 1'b0;
      req_op = OP_ADD; req_side = 1'b0; req_position = 8'd0; req_price = '0;
      req_size = 24'd0;
      csr_write = 1'b0; csr_index = CSR_ROW_LIMIT; csr_data = 40'd0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: build a book, extremes, out-of-step and unused ops
      send(OP_TRADE, 1'b0, 8'd0, 48'sd100, 24'd5);           // one-sided, dropped
      send(OP_ADD, 1'b0, 8'd0, 48'sd2000, 24'd10);
      send(OP_ADD, 1'b1, 8'd0, 48'sd1000, 24'hFFFFFF);
      send(OP_MODIFY, 1'b1, 8'd1, 48'sd900, 24'd3);          // append
      send(OP_ADD, 1'b1, 8'd0, 48'h7FFFFFFFFFFF, 24'd1);
      send(OP_ADD, 1'b0, 8'd1, 48'h800000000000, 24'd7);
      send(OP_ADD, 1'b0, 8'd5, 48'sd1, 24'd1);               // out of step
      send(OP_MODIFY, 1'b1, 8'hFF, 48'sd1, 24'd1);           // out of step
      send(OP_REMOVE, 1'b0, 8'd2, 48'sd0, 24'd0);            // out of step
      send(OP_MODIFY, 1'b1, 8'd0, 48'sd1000, 24'd0);         // zero size removes
      send(OP_REMOVE, 1'b0, 8'd1, 48'sd0, 24'd0);
      send(3'd5, 1'b1, 8'd0, 48'sd0, 24'd0);
      send(3'd6, 1'b0, 8'd0, 48'sd0, 24'd0);
      send(3'd7, 1'b1, 8'hAA, 48'h555555555555, 24'hAAAAAA);
      send(OP_TRADE, 1'b0, 8'd0, 48'sd2000, 24'd0);          // zero size, dropped
      send(OP_TRADE, 1'b0, 8'd0, 48'sd2000, 24'd4);          // buyer
      send(OP_TRADE, 1'b0, 8'd0, 48'sd1000, 24'd4);          // buyer under the default tolerance
      send(OP_TRADE, 1'b1, 8'd0, 48'sd1500, 24'd4);          // buyer, current touch
      send(OP_TRADE, 1'b1, 8'd0, -48'sd1, 24'hFFFFFF);
      send(OP_RESET, 1'b0, 8'd0, 48'sd0, 24'd0);
      send(OP_TRADE, 1'b0, 8'd0, 48'sd1, 24'd1);             // empty book, dropped

      // random phases over register settings, extremes included
      for (int ph = 0; ph < 5; ph++) begin
         drain();
         case (ph)
            0: begin write_reg(CSR_ROW_LIMIT, 40'd16); write_reg(CSR_PRICE_TOL, 40'd0); end
            1: begin write_reg(CSR_ROW_LIMIT, 40'd1);
                     write_reg(CSR_PRICE_TOL, 40'hFFFFFFFFFF); end
            2: begin write_reg(CSR_ROW_LIMIT, 40'd31); write_reg(CSR_PRICE_TOL, 40'd62500000); end
            3: begin write_reg(CSR_ROW_LIMIT, 40'd0);
                     write_reg(CSR_PRICE_TOL, {8'd0, 32'($urandom)}); end
            default: begin write_reg(CSR_ROW_LIMIT, 40'd3);
                     write_reg(CSR_PRICE_TOL, {$urandom, 8'($urandom)} & 40'hFFFFFFFFFF); end
         endcase
         for (int k = 0; k < 60; k++) begin
            steady = (ph == 2 && k >= 20 && k < 50);
            random_command();
         end
      end

      start <= 1'b0;
      @(posedge clock);
      while (levels_pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      failed = fail_count + levels_pending;
      if (failed == 0)
         $display("[depth_ladder_book_builder] OK");
      else
         $display("[depth_ladder_book_builder] ERROR");
      $finish;
   end

endmodule

// ----- filelist.f -----
design/dlbb_pkg.sv
design/dlbb_front.sv
design/dlbb_back.sv
design/depth_ladder_book_builder.sv
dv/dlbb_checker.sv
dv/tb_depth_ladder_book_builder.sv
